/* rtl/cwms_pkg.sv */
// ----------------------------------------------------------------------------
// cwms_pkg: shared types and helpers for the multiplexed seven-segment clock
// Holds the command codes, register indexes, time limits and the digit
// decoder used by the clock datapath.
// ----------------------------------------------------------------------------
package cwms_pkg;

    // Command codes carried by an input word. The remaining code is ignored.
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_SET     = 2'd2
    } cmd_t;

    // Register indexes on the configuration port.
    localparam logic REG_SCAN  = 1'b0;
    localparam logic REG_BLINK = 1'b1;

    // Reset values and limits.
    localparam logic [7:0] SCAN_RESET  = 8'd50;
    localparam logic [7:0] BLINK_RESET = 8'd100;
    localparam logic [6:0] SEG_DARK    = 7'h7F;
    localparam logic [3:0] EN_NONE     = 4'hF;
    localparam logic [5:0] SEC_WRAP    = 6'd60;
    localparam logic [5:0] MIN_WRAP    = 6'd60;
    localparam logic [4:0] HOUR_WRAP   = 5'd24;
    localparam logic [5:0] SEC_MAX     = 6'd59;
    localparam logic [5:0] MIN_MAX     = 6'd59;
    localparam logic [4:0] HOUR_MAX    = 5'd23;
    localparam logic [5:0] RADIX       = 6'd10;

    // Lit segments (a..g in bits 0..6) for the decimal digits.
    localparam logic [6:0] LIT_PATTERN [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Tens digit of a six-bit count, found by a short compare chain.
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)
            t = 3'd6;
        else if (v >= 6'd50)
            t = 3'd5;
        else if (v >= 6'd40)
            t = 3'd4;
        else if (v >= 6'd30)
            t = 3'd3;
        else if (v >= 6'd20)
            t = 3'd2;
        else if (v >= 6'd10)
            t = 3'd1;
        else
            t = 3'd0;
        return t;
    endfunction

    // Units digit of a six-bit count.
    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] r;
        r = v - (6'(tens_of(v)) * RADIX);
        return r[3:0];
    endfunction

    // Active-low seven-segment decoder; codes above nine stay dark.
    function automatic logic [6:0] decode_digit(input logic [3:0] d);
        logic [6:0] seg;
        if (d > 4'd9)
            seg = SEG_DARK;
        else
            seg = ~LIT_PATTERN[d] & SEG_DARK;
        return seg;
    endfunction

endpackage

/* rtl/clock_with_multiplexed_seven_segment.sv */
// ----------------------------------------------------------------------------
// clock_with_multiplexed_seven_segment: 24-hour clock with display scan
// Keeps seconds, minutes and hours, drives a blinking dot and scans four
// seven-segment digits, one word in and one result word out per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (cmd, set_seconds, set_minutes, set_hours) arrive on a
//   valid/ready channel; each one yields exactly one result word (segments,
//   digit enables, dot level and current time) on the output channel.
//   A word is captured in an input register, processed by the counter and
//   decoder logic once the output register can take it, and the result
//   lands in that output register. Throughput is one word per cycle while
//   the receiver does not stall, set by the single pass through the
//   counter and decoder logic between the two registers.
//   When the receiver stalls, the output register holds its word, the input
//   register holds the next one, and in_ready drops only when both are full.
//   Reset clears the time to 00:00:00, loads both countdowns and periods with
//   their defaults (scan 50, blink 100), darkens all segments and digits and
//   clears the dot. The user writes the periods over the APB port at byte
//   addresses 0 (scan) and 4 (blink) only while the block is idle, which it
//   does not enforce; a new period takes effect at the next countdown reload.
// ----------------------------------------------------------------------------
module clock_with_multiplexed_seven_segment (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [5:0]  set_seconds,
    input  logic [5:0]  set_minutes,
    input  logic [4:0]  set_hours,
    // Output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  segment_lines,
    output logic [3:0]  digit_enables,
    output logic        dot_level,
    output logic [5:0]  cur_seconds,
    output logic [5:0]  cur_minutes,
    output logic [4:0]  cur_hours
);
    import cwms_pkg::*;

    // Configuration registers
    logic [7:0] scan_period_reg;
    logic [7:0] blink_period_reg;
    logic       cfg_write;

    // Input word register
    logic       in_valid_reg;
    cmd_t       cmd_reg;
    logic [5:0] set_sec_reg;
    logic [5:0] set_min_reg;
    logic [4:0] set_hour_reg;

    // Clock and display state
    logic [5:0] sec_reg,   sec_next;
    logic [5:0] min_reg,   min_next;
    logic [4:0] hour_reg,  hour_next;
    logic [7:0] scan_cnt_reg,  scan_cnt_next;
    logic [7:0] blink_cnt_reg, blink_cnt_next;
    logic [1:0] scan_pos_reg,  scan_pos_next;
    logic [6:0] seg_reg,   seg_next;
    logic [3:0] en_reg,    en_next;
    logic       dot_reg,   dot_next;

    // Output word register
    logic       out_valid_reg;
    logic [6:0] out_seg_reg;
    logic [3:0] out_en_reg;
    logic       out_dot_reg;
    logic [5:0] out_sec_reg;
    logic [5:0] out_min_reg;
    logic [4:0] out_hour_reg;

    // Datapath helpers
    logic       out_free;
    logic       proc;
    logic [7:0] scan_dec;
    logic [7:0] blink_dec;
    logic [5:0] sec_inc;
    logic [5:0] min_inc;
    logic [4:0] hour_inc;
    logic [3:0] digit;
    logic       set_ok;

    // APB access: writes land on the access cycle, reads are combinational.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_BLINK) ? {24'd0, blink_period_reg}
                                               : {24'd0, scan_period_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg  <= SCAN_RESET;
            blink_period_reg <= BLINK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SCAN:  scan_period_reg  <= pwdata[7:0];
                REG_BLINK: blink_period_reg <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    // Handshake: a word is processed when the output register can take it.
    assign out_free = !out_valid_reg || out_ready;
    assign proc     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg      <= cmd_t'(cmd);
            set_sec_reg  <= set_seconds;
            set_min_reg  <= set_minutes;
            set_hour_reg <= set_hours;
        end
    end

    // Counter arithmetic used by the command arms.
    assign scan_dec  = scan_cnt_reg - 8'd1;
    assign blink_dec = blink_cnt_reg - 8'd1;
    assign sec_inc   = sec_reg + 6'd1;
    assign min_inc   = min_reg + 6'd1;
    assign hour_inc  = hour_reg + 5'd1;
    assign set_ok    = (set_sec_reg <= SEC_MAX) && (set_min_reg <= MIN_MAX)
                    && (set_hour_reg <= HOUR_MAX);

    // Digit selected by the scan position.
    always_comb
    begin
        unique case (scan_pos_reg)
            2'd0:    digit = units_of(min_reg);
            2'd1:    digit = {1'b0, tens_of(min_reg)};
            2'd2:    digit = units_of({1'b0, hour_reg});
            default: digit = {1'b0, tens_of({1'b0, hour_reg})};
        endcase
    end

    // Next state for the processed word.
    always_comb
    begin
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        scan_cnt_next  = scan_cnt_reg;
        blink_cnt_next = blink_cnt_reg;
        scan_pos_next  = scan_pos_reg;
        seg_next       = seg_reg;
        en_next        = en_reg;
        dot_next       = dot_reg;
        if (proc)
        begin
            unique case (cmd_reg)
                CMD_TICK:
                begin
                    if (blink_dec == 8'd0)
                    begin
                        blink_cnt_next = blink_period_reg;
                        dot_next       = ~dot_reg;
                    end
                    else
                        blink_cnt_next = blink_dec;
                    if (scan_dec == 8'd0)
                    begin
                        scan_cnt_next = scan_period_reg;
                        seg_next      = decode_digit(digit);
                        en_next       = ~(4'b0001 << scan_pos_reg);
                        scan_pos_next = scan_pos_reg + 2'd1;
                    end
                    else
                        scan_cnt_next = scan_dec;
                end
                CMD_ADVANCE:
                begin
                    if (sec_inc >= SEC_WRAP)
                    begin
                        sec_next = 6'd0;
                        if (min_inc >= MIN_WRAP)
                        begin
                            min_next  = 6'd0;
                            hour_next = (hour_inc >= HOUR_WRAP) ? 5'd0 : hour_inc;
                        end
                        else
                            min_next = min_inc;
                    end
                    else
                        sec_next = sec_inc;
                end
                CMD_SET:
                begin
                    if (set_ok)
                    begin
                        sec_next  = set_sec_reg;
                        min_next  = set_min_reg;
                        hour_next = set_hour_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 5'd0;
            scan_cnt_reg  <= SCAN_RESET;
            blink_cnt_reg <= BLINK_RESET;
            scan_pos_reg  <= 2'd0;
            seg_reg       <= SEG_DARK;
            en_reg        <= EN_NONE;
            dot_reg       <= 1'b0;
        end
        else
        begin
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            scan_cnt_reg  <= scan_cnt_next;
            blink_cnt_reg <= blink_cnt_next;
            scan_pos_reg  <= scan_pos_next;
            seg_reg       <= seg_next;
            en_reg        <= en_next;
            dot_reg       <= dot_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= proc;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_seg_reg  <= seg_next;
            out_en_reg   <= en_next;
            out_dot_reg  <= dot_next;
            out_sec_reg  <= sec_next;
            out_min_reg  <= min_next;
            out_hour_reg <= hour_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign segment_lines = out_seg_reg;
    assign digit_enables = out_en_reg;
    assign dot_level     = out_dot_reg;
    assign cur_seconds   = out_sec_reg;
    assign cur_minutes   = out_min_reg;
    assign cur_hours     = out_hour_reg;

`ifndef SYNTHESIS
    // The time counts never leave their ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sec_reg <= SEC_MAX) && (min_reg <= MIN_MAX) && (hour_reg <= HOUR_MAX))
        else $error("time count out of range");

    // At most one digit is enabled at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en_reg == EN_NONE) || $onehot(~en_reg))
        else $error("more than one digit enabled");

    // A processed word always produces a result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_valid_reg)
        else $error("processed word produced no result");

    // A pending input word that cannot move is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(cmd_reg)))
        else $error("pending input word lost");

    // The scan position advances only on a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (scan_pos_reg != scan_pos_next) |-> (proc && (cmd_reg == CMD_TICK)))
        else $error("scan position moved without a tick");
`endif

endmodule

/* tb/sv/tb_clock_with_multiplexed_seven_segment.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_with_multiplexed_seven_segment: self-checking bench for the clock
// Drives command words through the valid/ready input with random gaps and
// stalls, and reprograms both periods over APB between phases. Every result
// word is compared field by field against its directed row or an in-bench
// model of the clock, the blink and scan countdowns and the digit decoder.
// ----------------------------------------------------------------------------
module tb_clock_with_multiplexed_seven_segment;

    import cwms_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [2:0] ADDR_SCAN       = {REG_SCAN, 2'b00};
    localparam logic [2:0] ADDR_BLINK      = {REG_BLINK, 2'b00};
    localparam int         SECONDS_LIMIT   = 60;
    localparam int         MINUTES_LIMIT   = 60;
    localparam int         HOURS_LIMIT     = 24;
    localparam int         PHASES          = 7;
    localparam int         LONG_HOLD       = 400;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         CYCLE_LIMIT     = 500000;

    // One result word as the block presents it.
    typedef struct packed {
        logic [6:0] seg;
        logic [3:0] en;
        logic       dot;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
    } display_word_t;

    // One row of the directed table.
    typedef struct packed {
        logic [1:0]    op;
        logic [5:0]    s;
        logic [5:0]    m;
        logic [4:0]    h;
        logic          typed;
        display_word_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [5:0]  set_seconds;
    logic [5:0]  set_minutes;
    logic [4:0]  set_hours;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  segment_lines;
    logic [3:0]  digit_enables;
    logic        dot_level;
    logic [5:0]  cur_seconds;
    logic [5:0]  cur_minutes;
    logic [4:0]  cur_hours;

    // Clock model state.
    logic [7:0]    scan_period_now;
    logic [7:0]    blink_period_now;
    int            seconds_now;
    int            minutes_now;
    int            hours_now;
    logic [7:0]    scan_left;
    logic [7:0]    blink_left;
    logic [1:0]    scan_pos;
    logic [6:0]    seg_now;
    logic [3:0]    en_now;
    logic          dot_now;

    display_word_t expected_words[$];
    stim_row_t     directed_rows[$];
    display_word_t oldest_word;

    bit send_burst;
    bit recv_burst;
    bit hold_output;
    int mismatches;
    int words_checked;
    int digit_scans;
    int dot_toggles;
    int sets_rejected;
    int settings_used;
    int cycle_count;

    clock_with_multiplexed_seven_segment uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .set_seconds   (set_seconds),
        .set_minutes   (set_minutes),
        .set_hours     (set_hours),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .segment_lines (segment_lines),
        .digit_enables (digit_enables),
        .dot_level     (dot_level),
        .cur_seconds   (cur_seconds),
        .cur_minutes   (cur_minutes),
        .cur_hours     (cur_hours)
    );

    always #2 clk = ~clk;

    // Active-low segment pattern of one decimal digit; anything else is dark.
    function automatic logic [6:0] segments_for(input int digit);
        logic [6:0] seg;
        case (digit)
            0:       seg = 7'h40;
            1:       seg = 7'h79;
            2:       seg = 7'h24;
            3:       seg = 7'h30;
            4:       seg = 7'h19;
            5:       seg = 7'h12;
            6:       seg = 7'h02;
            7:       seg = 7'h78;
            8:       seg = 7'h00;
            9:       seg = 7'h10;
            default: seg = 7'h7F;
        endcase
        return seg;
    endfunction

    // Steps the clock model by one command word and returns what it shows.
    function automatic display_word_t clock_predict(input logic [1:0] op,
                                                    input logic [5:0] s,
                                                    input logic [5:0] m,
                                                    input logic [4:0] h);
        display_word_t w;
        int            digit;
        if (op == CMD_TICK) begin
            blink_left = blink_left - 8'd1;
            if (blink_left == 8'd0) begin
                blink_left = blink_period_now;
                dot_now = ~dot_now;
                dot_toggles++;
            end
            scan_left = scan_left - 8'd1;
            if (scan_left == 8'd0) begin
                scan_left = scan_period_now;
                case (scan_pos)
                    2'd0:    digit = minutes_now % 10;
                    2'd1:    digit = minutes_now / 10;
                    2'd2:    digit = hours_now % 10;
                    default: digit = hours_now / 10;
                endcase
                seg_now = segments_for(digit);
                en_now = ~(4'b0001 << scan_pos);
                scan_pos = scan_pos + 2'd1;
                digit_scans++;
            end
        end else if (op == CMD_ADVANCE) begin
            seconds_now++;
            if (seconds_now >= SECONDS_LIMIT) begin
                seconds_now = 0;
                minutes_now++;
            end
            if (minutes_now >= MINUTES_LIMIT) begin
                minutes_now = 0;
                hours_now++;
            end
            if (hours_now >= HOURS_LIMIT)
                hours_now = 0;
        end else if (op == CMD_SET) begin
            // A set word with any count out of range leaves the time alone.
            if (s < SECONDS_LIMIT && m < MINUTES_LIMIT && h < HOURS_LIMIT) begin
                seconds_now = s;
                minutes_now = m;
                hours_now = h;
            end else begin
                sets_rejected++;
            end
        end
        w.seg = seg_now;
        w.en = en_now;
        w.dot = dot_now;
        w.sec = 6'(seconds_now);
        w.min = 6'(minutes_now);
        w.hr = 5'(hours_now);
        return w;
    endfunction

    // Directed row; typed rows expect a dark display showing the given time.
    task automatic add_row(input logic [1:0] op, input logic [5:0] s,
                           input logic [5:0] m, input logic [4:0] h,
                           input logic typed, input logic [5:0] cs,
                           input logic [5:0] cm, input logic [4:0] ch);
        stim_row_t row;
        row.op = op;
        row.s = s;
        row.m = m;
        row.h = h;
        row.typed = typed;
        row.want = '{SEG_DARK, EN_NONE, 1'b0, cs, cm, ch};
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // One APB transfer, with the bus idle before its setup phase.
    task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic register_matches(input logic [2:0] addr, input logic [7:0] want,
                                    input string name);
        logic [31:0] got;
        apb_transfer(1'b0, addr, 32'd0, got);
        check_field(name, {24'd0, want}, got);
    endtask

    task automatic set_period(input logic [2:0] addr, input logic [7:0] value,
                              input string name);
        logic [31:0] unused_read;
        apb_transfer(1'b1, addr, {24'd0, value}, unused_read);
        register_matches(addr, value, name);
    endtask

    // Offers one word after a random gap and records what it should show.
    task automatic send_word(input logic [1:0] op, input logic [5:0] s,
                             input logic [5:0] m, input logic [4:0] h,
                             input logic typed, input display_word_t want);
        int            gap;
        display_word_t predicted;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        set_seconds <= s;
        set_minutes <= m;
        set_hours <= h;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = clock_predict(op, s, m, h);
        expected_words.push_back(typed ? want : predicted);
    endtask

    // Stop offering and wait for every outstanding result word.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
    endtask

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_clock_with_multiplexed_seven_segment: FAIL");
            $finish;
        end
    end

    // Result checker: compare each accepted word with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word arrived with none expected");
                mismatches++;
            end else begin
                oldest_word = expected_words.pop_front();
                check_field("segment_lines", oldest_word.seg, segment_lines);
                check_field("digit_enables", oldest_word.en, digit_enables);
                check_field("dot_level", oldest_word.dot, dot_level);
                check_field("cur_seconds", oldest_word.sec, cur_seconds);
                check_field("cur_minutes", oldest_word.min, cur_minutes);
                check_field("cur_hours", oldest_word.hr, cur_hours);
                words_checked++;
            end
        end
    end

    // Receiver: random stall before each word, plus one long hold on request.
    initial begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = recv_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Main sequence: reset, directed table, then random phases per setting.
    initial begin
        int            phase;
        int            n;
        int            items;
        int            tick_pct;
        int            pick;
        logic [7:0]    scan_set;
        logic [7:0]    blink_set;
        logic [1:0]    op;
        logic [5:0]    s;
        logic [5:0]    m;
        logic [4:0]    h;
        display_word_t no_word;

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        cmd <= CMD_TICK;
        set_seconds <= '0;
        set_minutes <= '0;
        set_hours <= '0;
        no_word = '0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        hold_output = 1'b0;

        scan_period_now = SCAN_RESET;
        blink_period_now = BLINK_RESET;
        seconds_now = 0;
        minutes_now = 0;
        hours_now = 0;
        scan_left = SCAN_RESET;
        blink_left = BLINK_RESET;
        scan_pos = 2'd0;
        seg_now = SEG_DARK;
        en_now = EN_NONE;
        dot_now = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        register_matches(ADDR_SCAN, SCAN_RESET, "scan_period");
        register_matches(ADDR_BLINK, BLINK_RESET, "blink_period");
        settings_used = 1;

        // Directed part: unused code, carries, full wrap and rejected sets.
        add_row(CMD_UNUSED, 6'd63, 6'd63, 5'd31, 1'b1, 6'd0, 6'd0, 5'd0);
        add_row(CMD_ADVANCE, 6'd0, 6'd0, 5'd0, 1'b1, 6'd1, 6'd0, 5'd0);
        add_row(CMD_SET, 6'd59, 6'd59, 5'd23, 1'b1, 6'd59, 6'd59, 5'd23);
        add_row(CMD_ADVANCE, 6'd0, 6'd0, 5'd0, 1'b1, 6'd0, 6'd0, 5'd0);
        add_row(CMD_SET, 6'd60, 6'd0, 5'd0, 1'b1, 6'd0, 6'd0, 5'd0);
        add_row(CMD_SET, 6'd0, 6'd60, 5'd0, 1'b1, 6'd0, 6'd0, 5'd0);
        add_row(CMD_SET, 6'd0, 6'd0, 5'd24, 1'b1, 6'd0, 6'd0, 5'd0);
        add_row(CMD_SET, 6'd63, 6'd63, 5'd31, 1'b1, 6'd0, 6'd0, 5'd0);
        add_row(CMD_SET, 6'd59, 6'd9, 5'd19, 1'b1, 6'd59, 6'd9, 5'd19);
        add_row(CMD_ADVANCE, 6'd0, 6'd0, 5'd0, 1'b1, 6'd0, 6'd10, 5'd19);
        add_row(CMD_SET, 6'd59, 6'd59, 5'd9, 1'b1, 6'd59, 6'd59, 5'd9);
        add_row(CMD_ADVANCE, 6'd0, 6'd0, 5'd0, 1'b1, 6'd0, 6'd0, 5'd10);
        add_row(CMD_SET, 6'd0, 6'd0, 5'd0, 1'b1, 6'd0, 6'd0, 5'd0);
        add_row(CMD_TICK, 6'd63, 6'd63, 5'd31, 1'b1, 6'd0, 6'd0, 5'd0);
        add_row(CMD_SET, 6'd42, 6'd37, 5'd18, 1'b0, 6'd0, 6'd0, 5'd0);
        add_row(CMD_TICK, 6'd0, 6'd0, 5'd0, 1'b0, 6'd0, 6'd0, 5'd0);
        add_row(CMD_UNUSED, 6'd0, 6'd0, 5'd0, 1'b0, 6'd0, 6'd0, 5'd0);
        add_row(CMD_ADVANCE, 6'd21, 6'd42, 5'd10, 1'b0, 6'd0, 6'd0, 5'd0);
        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].s, directed_rows[i].m,
                      directed_rows[i].h, directed_rows[i].typed, directed_rows[i].want);

        for (phase = 0; phase < PHASES; phase++) begin
            // Reprogram both periods while nothing is in flight.
            if (phase > 0) begin
                drain_results();
                case (phase)
                    1: begin scan_set = 8'd1;   blink_set = 8'd1;   end
                    2: begin scan_set = 8'd255; blink_set = 8'd255; end
                    3: begin scan_set = 8'd0;   blink_set = 8'd0;   end
                    4: begin scan_set = 8'd1;   blink_set = 8'd255; end
                    5: begin scan_set = 8'd255; blink_set = 8'd1;   end
                    default: begin
                        scan_set = 8'($urandom_range(1, 254));
                        blink_set = 8'($urandom_range(1, 254));
                    end
                endcase
                set_period(ADDR_SCAN, scan_set, "scan_period");
                set_period(ADDR_BLINK, blink_set, "blink_period");
                scan_period_now = scan_set;
                blink_period_now = blink_set;
                settings_used++;
            end

            send_burst = (phase == 2) || (phase == 3) || (phase == 5);
            recv_burst = (phase == 3) || (phase == 4);
            // Long output hold while the sender keeps pushing at full rate.
            if (phase == 2)
                hold_output = 1'b1;
            // A zero period needs many ticks before the countdowns come around.
            items = (phase == 3) ? 600 : 230;
            tick_pct = (phase == 3) ? 90 : 45;

            for (n = 0; n < items; n++) begin
                s = 6'($urandom_range(0, 63));
                m = 6'($urandom_range(0, 63));
                h = 5'($urandom_range(0, 31));
                pick = $urandom_range(0, 99);
                if (pick < tick_pct) begin
                    op = CMD_TICK;
                end else if (pick < tick_pct + (100 - tick_pct) * 5 / 10) begin
                    op = CMD_ADVANCE;
                end else if (pick < tick_pct + (100 - tick_pct) * 8 / 10) begin
                    // Well-formed set, often close to a carry.
                    op = CMD_SET;
                    s = $urandom_range(0, 1) ? 6'(57 + $urandom_range(0, 2))
                                             : 6'($urandom_range(0, 59));
                    m = $urandom_range(0, 1) ? 6'(58 + $urandom_range(0, 1))
                                             : 6'($urandom_range(0, 59));
                    h = $urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 23));
                end else if (pick < tick_pct + (100 - tick_pct) * 9 / 10) begin
                    op = CMD_SET;
                end else begin
                    op = CMD_UNUSED;
                end
                send_word(op, s, m, h, 1'b0, no_word);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            mismatches++;
        end

        $display("Checked %0d result words across %0d period settings.",
                 words_checked, settings_used);
        $display("Saw %0d digit scans, %0d dot toggles and %0d rejected set words.",
                 digit_scans, dot_toggles, sets_rejected);
        if (mismatches == 0)
            $display("tb_clock_with_multiplexed_seven_segment: PASS");
        else
            $display("tb_clock_with_multiplexed_seven_segment: FAIL");
        $finish;
    end

endmodule
